// ----- rtl/fpa_pkg.sv -----
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int WORD_BITS = 32;

  // numerator of a divide is |a| << FRAC_BITS, padded to whole radix-4 steps
  localparam int NUM_W      = WORD_BITS + FRAC_BITS;
  localparam int DIV_STAGES = (NUM_W + 1) / 2;
  localparam int NUM_PAD    = 2 * DIV_STAGES;
  localparam int PROD_W     = 2 * WORD_BITS;
  localparam int MAG_W      = (PROD_W > NUM_PAD + 1) ? PROD_W : NUM_PAD + 1;

  localparam int IN_DATA_W  = 2 * WORD_BITS;
  localparam int OUT_DATA_W = ((WORD_BITS + 3 + 7) / 8) * 8;

  localparam logic [3:0] OP_ADD      = 4'd0;
  localparam logic [3:0] OP_SUB      = 4'd1;
  localparam logic [3:0] OP_MUL      = 4'd2;
  localparam logic [3:0] OP_DIV      = 4'd3;
  localparam logic [3:0] OP_LT       = 4'd4;
  localparam logic [3:0] OP_GT       = 4'd5;
  localparam logic [3:0] OP_LE       = 4'd6;
  localparam logic [3:0] OP_GE       = 4'd7;
  localparam logic [3:0] OP_EQ       = 4'd8;
  localparam logic [3:0] OP_NE       = 4'd9;
  localparam logic [3:0] OP_MIN      = 4'd10;
  localparam logic [3:0] OP_MAX      = 4'd11;
  localparam logic [3:0] OP_INC      = 4'd12;
  localparam logic [3:0] OP_DEC      = 4'd13;
  localparam logic [3:0] OP_TO_INT   = 4'd14;
  localparam logic [3:0] OP_FROM_INT = 4'd15;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  typedef struct packed {
    logic [3:0]           op;
    logic [WORD_BITS-1:0] res;
    logic                 flag;
    logic [1:0]           status;
    logic                 neg;
    logic                 bzero;
    logic [WORD_BITS-1:0] mb;
    logic [NUM_PAD-1:0]   num;
    logic [WORD_BITS:0]   rem;
    logic [NUM_PAD-1:0]   quo;
    logic [PROD_W-1:0]    prod;
  } stage_t;

endpackage

// ----- rtl/fixed_point_alu_top.sv -----
// signed fixed-point alu, q24.8 words, one operation per request
// input channel s_axis: tuser carries the operation code, tdata the two raw
//   operands (a in the low word, b in the high word)
// output channel m_axis: tdata carries result value, compare flag and status
// every request gives exactly one output request, in order
// the pipeline depth is set by the divider, which retires two quotient bits a stage
// throughput: one request per cycle unless the receiver stalls, all operations share the same pipeline
// the 32x32 magnitude product is formed in the first divider stage and
//   rounded and saturated with the quotient in the final stage
// when the receiver stalls with a result waiting, the whole pipeline holds
//   and s_axis_tready_o drops; nothing is lost or repeated
// reset clears all valid bits; the block is ready as soon as reset is released
module fixed_point_alu_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // operand_a [31:0], operand_b [63:32]
  input  logic [fpa_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  // operation [3:0]
  input  logic [3:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // result_value [31:0], compare_flag [32], status [34:33], zero fill above
  output logic [fpa_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import fpa_pkg::*;

  localparam int W = WORD_BITS;
  localparam logic [PROD_W-1:0] MUL_RND = PROD_W'(2 ** FRAC_BITS) >> 1;
  localparam logic [MAG_W-1:0]  POS_LIM = MAG_W'({1'b0, {(W-1){1'b1}}});

  typedef struct packed {
    logic [W-1:0] res;
    logic         ovf;
  } sat_t;

  function automatic stage_t div_step(stage_t s);
    stage_t        o;
    logic [W:0]    r;
    o = s;
    for (int i = 0; i < 2; i++) begin
      r = {o.rem[W-1:0], o.num[NUM_PAD-1]};
      o.num = {o.num[NUM_PAD-2:0], 1'b0};
      if (r >= {1'b0, o.mb}) begin
        o.rem = r - {1'b0, o.mb};
        o.quo = {o.quo[NUM_PAD-2:0], 1'b1};
      end else begin
        o.rem = r;
        o.quo = {o.quo[NUM_PAD-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  function automatic sat_t sat_mag(logic neg, logic [MAG_W-1:0] v);
    sat_t             o;
    logic [MAG_W-1:0] lim;
    logic [MAG_W-1:0] m;
    lim = neg ? POS_LIM + MAG_W'(1) : POS_LIM;
    o.ovf = v > lim;
    m = o.ovf ? lim : v;
    o.res = neg ? W'(-m) : m[W-1:0];
    return o;
  endfunction

  stage_t             pipe_q [0:DIV_STAGES];
  stage_t             pipe_d [0:DIV_STAGES];
  logic [DIV_STAGES:0] vld_q;
  logic               out_vld_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic               adv;

  assign adv = ~out_vld_q | m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o = out_data_q;

  // front stage: simple operations finish here, magnitudes for mul and div
  always_comb begin
    logic signed [W-1:0] a, b;
    logic [W:0]          sum;
    logic [W-1:0]        ma;
    logic [W-1:0]        sat_v;
    stage_t              s;
    a = s_axis_tdata_i[W-1:0];
    b = s_axis_tdata_i[2*W-1:W];
    s = '0;
    s.op = s_axis_tuser_i;
    s.status = ST_OK;
    case (s_axis_tuser_i)
      OP_SUB:  sum = {a[W-1], a} - {b[W-1], b};
      OP_INC:  sum = {a[W-1], a} + (W+1)'(1);
      OP_DEC:  sum = {a[W-1], a} - (W+1)'(1);
      default: sum = {a[W-1], a} + {b[W-1], b};
    endcase
    sat_v = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    case (s_axis_tuser_i)
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        if (sum[W] != sum[W-1]) begin
          s.res = sat_v;
          s.status = ST_OVF;
        end else begin
          s.res = sum[W-1:0];
        end
      end
      OP_LT:  s.flag = a < b;
      OP_GT:  s.flag = a > b;
      OP_LE:  s.flag = a <= b;
      OP_GE:  s.flag = a >= b;
      OP_EQ:  s.flag = a == b;
      OP_NE:  s.flag = a != b;
      OP_MIN: s.res = (a < b) ? a : b;
      OP_MAX: s.res = (a > b) ? a : b;
      OP_TO_INT: s.res = a >>> FRAC_BITS;
      OP_FROM_INT: begin
        if (a[W-1 -: FRAC_BITS+1] != {(FRAC_BITS+1){a[W-1]}}) begin
          s.res = a[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
          s.status = ST_OVF;
        end else begin
          s.res = a <<< FRAC_BITS;
        end
      end
      default: ;
    endcase
    ma = a[W-1] ? W'(-a) : a;
    s.mb = b[W-1] ? W'(-b) : b;
    s.neg = a[W-1] ^ b[W-1];
    s.bzero = (b == '0);
    s.num = NUM_PAD'({ma, {FRAC_BITS{1'b0}}});
    pipe_d[0] = s;
  end

  // divider stages, the product rides along from the first one
  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
    if (k == 1) begin : g_first
      always_comb begin
        stage_t s;
        s = pipe_q[0];
        s.prod = PROD_W'(s.num[FRAC_BITS +: W]) * PROD_W'(s.mb);
        pipe_d[1] = div_step(s);
      end
    end else begin : g_rest
      assign pipe_d[k] = div_step(pipe_q[k-1]);
    end
  end

  // round half away from zero and saturate
  always_comb begin
    stage_t           s;
    logic [MAG_W-1:0] qv;
    logic [MAG_W-1:0] pv;
    sat_t             sq, sp;
    logic [W-1:0]     res;
    logic [1:0]       st;
    s = pipe_q[DIV_STAGES];
    qv = MAG_W'(s.quo) + MAG_W'(({s.rem, 1'b0} >= {2'b00, s.mb}) ? 1 : 0);
    pv = MAG_W'((s.prod + MUL_RND) >> FRAC_BITS);
    sq = sat_mag(s.neg, qv);
    sp = sat_mag(s.neg, pv);
    res = s.res;
    st = s.status;
    case (s.op)
      OP_MUL: begin
        res = sp.res;
        st = sp.ovf ? ST_OVF : ST_OK;
      end
      OP_DIV: begin
        if (s.bzero) begin
          res = '0;
          st = ST_DIVZ;
        end else begin
          res = sq.res;
          st = sq.ovf ? ST_OVF : ST_OK;
        end
      end
      default: ;
    endcase
    out_data_d = OUT_DATA_W'({st, s.flag, res});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q <= {vld_q[DIV_STAGES-1:0], s_axis_tvalid_i};
      out_vld_q <= vld_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= DIV_STAGES; k++) begin
        pipe_q[k] <= pipe_d[k];
      end
      out_data_q <= out_data_d;
    end
  end

endmodule

// ----- verif/fixed_point_alu_top_tb.sv -----
`timescale 1ns / 100ps

module fixed_point_alu_top_tb;
  import fpa_pkg::*;

  localparam int LATENCY = DIV_STAGES + 2;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [WORD_BITS-1:0] value;
    logic                 flag;
    logic [1:0]           status;
  } alu_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic [3:0]            s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;

  alu_result_t expected_results[$];
  int          error_count;
  int          cycle_count;
  bit          stall_enable;

  fixed_point_alu_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  localparam logic signed [WORD_BITS-1:0] MAX_WORD = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] MIN_WORD = {1'b1, {(WORD_BITS-1){1'b0}}};

  // wide signed value to word with saturation
  function automatic alu_result_t saturate(input logic signed [2*WORD_BITS+8:0] v);
    alu_result_t r;
    r = '0;
    if (v > MAX_WORD) begin
      r.value = MAX_WORD;
      r.status = ST_OVF;
    end else if (v < MIN_WORD) begin
      r.value = MIN_WORD;
      r.status = ST_OVF;
    end else begin
      r.value = v[WORD_BITS-1:0];
    end
    return r;
  endfunction

  function automatic alu_result_t alu_predict(input logic [3:0] op,
                                              input logic signed [WORD_BITS-1:0] a,
                                              input logic signed [WORD_BITS-1:0] b);
    alu_result_t r;
    logic signed [2*WORD_BITS+8:0] wa, wb, w;
    logic [2*WORD_BITS+8:0] ma, mb, q, rm;
    bit neg;
    r = '0;
    wa = a;
    wb = b;
    ma = (a < 0) ? -wa : wa;
    mb = (b < 0) ? -wb : wb;
    neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
    case (op)
      OP_ADD: r = saturate(wa + wb);
      OP_SUB: r = saturate(wa - wb);
      OP_MUL: begin
        // magnitudes, round half away from zero
        q = (ma * mb + (1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        w = q;
        r = saturate(neg ? -w : w);
      end
      OP_DIV: begin
        if (b == 0) begin
          r.status = ST_DIVZ;
        end else begin
          q = (ma << FRAC_BITS) / mb;
          rm = (ma << FRAC_BITS) % mb;
          if (rm >= mb - rm) q = q + 1;
          w = q;
          r = saturate(neg ? -w : w);
        end
      end
      OP_LT: r.flag = a < b;
      OP_GT: r.flag = a > b;
      OP_LE: r.flag = a <= b;
      OP_GE: r.flag = a >= b;
      OP_EQ: r.flag = a == b;
      OP_NE: r.flag = a != b;
      OP_MIN: r.value = (a < b) ? a : b;
      OP_MAX: r.value = (a > b) ? a : b;
      OP_INC: r = saturate(wa + 1);
      OP_DEC: r = saturate(wa - 1);
      OP_TO_INT: r.value = a >>> FRAC_BITS;
      default: r = saturate(wa <<< FRAC_BITS);
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_BITS-1:0] got,
                                 input logic [WORD_BITS-1:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  // random gap, mostly short with an occasional long one
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if (!stall_enable) n = 0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic send_request(input logic [3:0] op, input logic [WORD_BITS-1:0] a,
                              input logic [WORD_BITS-1:0] b);
    if ($urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
      idle_gap();
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {b, a};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_results.push_back(alu_predict(op, a, b));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [WORD_BITS-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return MAX_WORD;
      1: return MIN_WORD;
      2: return $urandom_range(0, 4) - 2;
      3: return $urandom_range(0, 1 << 16) - (1 << 15);
      4: return $urandom_range(0, 1 << 24) - (1 << 23);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [WORD_BITS-1:0] edge_vals[5];
    edge_vals = '{MAX_WORD, MIN_WORD, 0, 1 << FRAC_BITS, -1};
    for (int op = 0; op < 16; op++)
      send_request(4'(op), edge_vals[op % 5], edge_vals[(op + 2) % 5]);
    send_request(OP_DIV, 32'h100, 0);
    send_request(OP_MUL, 32'h180, 32'h1);
    send_request(OP_MUL, -32'sh180, 32'h1);
    send_request(OP_DIV, 32'h1, 32'h200);
    send_request(OP_INC, MAX_WORD, 0);
    send_request(OP_DEC, MIN_WORD, 0);
    send_request(OP_FROM_INT, 32'h0080_0000, 0);
    send_request(OP_FROM_INT, 32'hFF80_0000, 0);
    send_request(OP_TO_INT, -32'sd1, 0);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++)
      send_request(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
  endtask

  task automatic test_back_to_back(input int count);
    stall_enable = 1'b0;
    for (int i = 0; i < count; i++) begin
      s_axis_tvalid_i <= 1'b1;
      s_axis_tuser_i  <= 4'($urandom_range(0, 15));
      s_axis_tdata_i  <= {$urandom, $urandom};
      @(posedge clk_i);
      while (!s_axis_tready_o) @(posedge clk_i);
      expected_results.push_back(alu_predict(s_axis_tuser_i, s_axis_tdata_i[WORD_BITS-1:0],
                                             s_axis_tdata_i[2*WORD_BITS-1:WORD_BITS]));
      @(negedge clk_i);
    end
    stall_enable = 1'b1;
  endtask

  // result checker
  always @(posedge clk_i) begin
    alu_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected request", m_axis_tdata_o[WORD_BITS-1:0], '0);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata_o[WORD_BITS-1:0] !== want.value)
          report_mismatch("value", m_axis_tdata_o[WORD_BITS-1:0], want.value);
        if (m_axis_tdata_o[WORD_BITS] !== want.flag)
          report_mismatch("flag", WORD_BITS'(m_axis_tdata_o[WORD_BITS]),
                          WORD_BITS'(want.flag));
        if (m_axis_tdata_o[WORD_BITS+2:WORD_BITS+1] !== want.status)
          report_mismatch("status", WORD_BITS'(m_axis_tdata_o[WORD_BITS+2:WORD_BITS+1]),
                          WORD_BITS'(want.status));
      end
    end
  end

  // receiver stalls
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_enable && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i <= 1'b0;
        idle_gap();
        @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    error_count = 0;
    stall_enable = 1'b1;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    drain_results();
    test_random(700);
    // hold off until the pipeline is empty
    drain_results();
    test_back_to_back(200);
    test_random(575);
    drain_results();
    repeat (LATENCY + 10) @(negedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/fpa_pkg.sv
rtl/fixed_point_alu_top.sv
verif/fixed_point_alu_top_tb.sv
